>>> rtl/core/cps_pkg.sv
// Package for the critical path scheduler: field widths, time limits,
// item modes, and the controller's state, phase and command types.
// Depends on nothing; every other file of the block uses it.
package cps_pkg;

  localparam int MaxTasks     = 64;
  localparam int MaxEdges     = 1024;
  localparam int DurationBits = 16;

  localparam int TaskW  = 6;
  localparam int CountW = 7;
  localparam int TimeW  = 22;
  localparam logic [TimeW-1:0] TimeMax = 22'h3FFFFF;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  // Which edge walk is in progress; selects the match rule and the update.
  typedef enum logic [1:0] {
    PH_COUNT,
    PH_KAHN,
    PH_FWD,
    PH_BWD
  } phase_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ZERO,
    ST_WRD,
    ST_WCHK,
    ST_WUPD,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_POP,
    ST_GET,
    ST_ACC,
    ST_EI_RD,
    ST_EI_WR,
    ST_PJ_RD,
    ST_PJ_WR,
    ST_LI,
    ST_O_RD,
    ST_O_WR,
    ST_ERR
  } ctl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_ZERO,
    OP_EREAD,
    OP_ECHK,
    OP_EUPD,
    OP_SEED_WR,
    OP_GET,
    OP_ACC,
    OP_EI_WR,
    OP_PJ_WR,
    OP_LI,
    OP_EMIT,
    OP_ERR
  } op_e;

  typedef struct packed {
    op_e    op;
    phase_e phase;
    logic   item_ready;
  } cmd_t;

  typedef struct packed {
    logic  item_valid;
    mode_e item_mode;
    logic  e_done;
    logic  hit;
    logic  i_last;
    logic  q_empty;
    logic  tail_short;
    logic  head_at_n;
    logic  head_zero;
    logic  out_free;
  } status_t;

endpackage

>>> rtl/core/cps_if.sv
// Channel interfaces of the critical path scheduler: item input, result
// output and the task count write port. Uses cps_pkg for field widths.
interface cps_item_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [cps_pkg::TaskW-1:0]  task_id;
  logic [15:0]                task_duration;
  logic [cps_pkg::TaskW-1:0]  edge_from;
  logic [cps_pkg::TaskW-1:0]  edge_to;
  modport source (output valid, mode, task_id, task_duration, edge_from, edge_to,
                  input ready);
  modport sink (input valid, mode, task_id, task_duration, edge_from, edge_to,
                output ready);
endinterface

interface cps_result_if;
  logic                       valid;
  logic                       ready;
  logic [cps_pkg::TaskW-1:0]  result_task;
  logic [cps_pkg::TimeW-1:0]  earliest_finish;
  logic [cps_pkg::TimeW-1:0]  latest_finish;
  logic [cps_pkg::TimeW-1:0]  slack_time;
  logic                       on_critical_path;
  logic [cps_pkg::TimeW-1:0]  project_time;
  logic                       cycle_error;
  logic                       edge_overflow;
  logic                       last_result;
  modport source (output valid, result_task, earliest_finish, latest_finish, slack_time,
                  on_critical_path, project_time, cycle_error, edge_overflow,
                  last_result, input ready);
  modport sink (input valid, result_task, earliest_finish, latest_finish, slack_time,
                on_critical_path, project_time, cycle_error, edge_overflow,
                last_result, output ready);
endinterface

interface cps_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [cps_pkg::CountW-1:0] task_count;
  modport source (output valid, task_count, input ready);
  modport sink (input valid, task_count, output ready);
endinterface

>>> rtl/core/cps_ctrl.sv
// Sequencing state machine of the critical path scheduler.
// Uses cps_pkg; drives cps_dp through cmd_t and reads its status_t.
module cps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cps_pkg::status_t st_i,
  output cps_pkg::cmd_t    cmd_o
);

  cps_pkg::ctl_state_e state_q, state_d;
  cps_pkg::phase_e     phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cps_pkg::ST_IDLE;
      phase_q <= cps_pkg::PH_COUNT;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    unique case (state_q)
      cps_pkg::ST_IDLE: begin
        if (st_i.item_valid && st_i.item_mode == cps_pkg::MODE_RUN) begin
          state_d = cps_pkg::ST_ZERO;
        end
      end
      cps_pkg::ST_ZERO: begin
        if (st_i.i_last) begin
          state_d = cps_pkg::ST_WRD;
          phase_d = cps_pkg::PH_COUNT;
        end
      end
      cps_pkg::ST_WRD: begin
        if (st_i.e_done) begin
          unique case (phase_q)
            cps_pkg::PH_COUNT: state_d = cps_pkg::ST_SEED_RD;
            default:           state_d = cps_pkg::ST_POP;
          endcase
        end else begin
          state_d = cps_pkg::ST_WCHK;
        end
      end
      cps_pkg::ST_WCHK:    state_d = st_i.hit ? cps_pkg::ST_WUPD : cps_pkg::ST_WRD;
      cps_pkg::ST_WUPD:    state_d = cps_pkg::ST_WRD;
      cps_pkg::ST_SEED_RD: state_d = cps_pkg::ST_SEED_WR;
      cps_pkg::ST_SEED_WR: begin
        if (st_i.i_last) begin
          state_d = cps_pkg::ST_POP;
          phase_d = cps_pkg::PH_KAHN;
        end else begin
          state_d = cps_pkg::ST_SEED_RD;
        end
      end
      cps_pkg::ST_POP: begin
        unique case (phase_q)
          cps_pkg::PH_KAHN: begin
            if (st_i.q_empty) begin
              state_d = st_i.tail_short ? cps_pkg::ST_ERR : cps_pkg::ST_EI_RD;
            end else begin
              state_d = cps_pkg::ST_GET;
            end
          end
          cps_pkg::PH_FWD: state_d = st_i.head_at_n ? cps_pkg::ST_PJ_RD : cps_pkg::ST_GET;
          default:         state_d = st_i.head_zero ? cps_pkg::ST_O_RD : cps_pkg::ST_GET;
        endcase
      end
      cps_pkg::ST_GET: begin
        state_d = (phase_q == cps_pkg::PH_KAHN) ? cps_pkg::ST_WRD : cps_pkg::ST_ACC;
      end
      cps_pkg::ST_ACC:   state_d = cps_pkg::ST_WRD;
      cps_pkg::ST_EI_RD: state_d = cps_pkg::ST_EI_WR;
      cps_pkg::ST_EI_WR: begin
        if (st_i.i_last) begin
          state_d = cps_pkg::ST_POP;
          phase_d = cps_pkg::PH_FWD;
        end else begin
          state_d = cps_pkg::ST_EI_RD;
        end
      end
      cps_pkg::ST_PJ_RD: state_d = cps_pkg::ST_PJ_WR;
      cps_pkg::ST_PJ_WR: state_d = st_i.i_last ? cps_pkg::ST_LI : cps_pkg::ST_PJ_RD;
      cps_pkg::ST_LI: begin
        if (st_i.i_last) begin
          state_d = cps_pkg::ST_POP;
          phase_d = cps_pkg::PH_BWD;
        end
      end
      cps_pkg::ST_O_RD: state_d = cps_pkg::ST_O_WR;
      cps_pkg::ST_O_WR: begin
        if (st_i.out_free) begin
          state_d = st_i.i_last ? cps_pkg::ST_IDLE : cps_pkg::ST_O_RD;
        end
      end
      cps_pkg::ST_ERR: begin
        if (st_i.out_free) begin
          state_d = cps_pkg::ST_IDLE;
        end
      end
      default: state_d = cps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op         = cps_pkg::OP_NONE;
    cmd_o.phase      = phase_q;
    cmd_o.item_ready = 1'b0;
    unique case (state_q)
      cps_pkg::ST_IDLE: begin
        cmd_o.item_ready = 1'b1;
        if (st_i.item_valid) begin
          cmd_o.op = (st_i.item_mode == cps_pkg::MODE_RUN) ? cps_pkg::OP_START
                                                            : cps_pkg::OP_LOAD;
        end
      end
      cps_pkg::ST_ZERO:    cmd_o.op = cps_pkg::OP_ZERO;
      cps_pkg::ST_WRD:     cmd_o.op = cps_pkg::OP_EREAD;
      cps_pkg::ST_WCHK:    cmd_o.op = cps_pkg::OP_ECHK;
      cps_pkg::ST_WUPD:    cmd_o.op = cps_pkg::OP_EUPD;
      cps_pkg::ST_SEED_WR: cmd_o.op = cps_pkg::OP_SEED_WR;
      cps_pkg::ST_GET:     cmd_o.op = cps_pkg::OP_GET;
      cps_pkg::ST_ACC:     cmd_o.op = cps_pkg::OP_ACC;
      cps_pkg::ST_EI_WR:   cmd_o.op = cps_pkg::OP_EI_WR;
      cps_pkg::ST_PJ_WR:   cmd_o.op = cps_pkg::OP_PJ_WR;
      cps_pkg::ST_LI:      cmd_o.op = cps_pkg::OP_LI;
      cps_pkg::ST_O_WR:    cmd_o.op = st_i.out_free ? cps_pkg::OP_EMIT : cps_pkg::OP_NONE;
      cps_pkg::ST_ERR:     cmd_o.op = st_i.out_free ? cps_pkg::OP_ERR : cps_pkg::OP_NONE;
      default:             cmd_o.op = cps_pkg::OP_NONE;
    endcase
  end

endmodule

>>> rtl/core/cps_dp.sv
// Datapath of the critical path scheduler: task and edge stores, working
// stores, counters and the result register. Uses cps_pkg and cps_if;
// commanded by cps_ctrl.
module cps_dp #(
  parameter int MAX_TASKS     = cps_pkg::MaxTasks,
  parameter int MAX_EDGES     = cps_pkg::MaxEdges,
  parameter int DURATION_BITS = cps_pkg::DurationBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cps_pkg::cmd_t      cmd_i,
  output cps_pkg::status_t   st_o,
  cps_item_if.sink           item_i,
  cps_cfg_if.sink            cfg_i,
  cps_result_if.source       result_o
);

  localparam int TAW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TCW = $clog2(MAX_TASKS + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int CW  = cps_pkg::CountW;
  localparam int TW  = cps_pkg::TimeW;
  localparam int XW  = 34;

  // Memories.
  logic [11:0]              edge_mem [MAX_EDGES];
  logic [ETW-1:0]           ind_mem  [MAX_TASKS];
  logic [TAW-1:0]           ord_mem  [MAX_TASKS];
  logic [TW-1:0]            ear_mem  [MAX_TASKS];
  logic [TW-1:0]            lat_mem  [MAX_TASKS];
  logic [DURATION_BITS-1:0] dur_mem  [MAX_TASKS];
  logic [MAX_TASKS-1:0]     dur_vld_q;

  logic [11:0]              edge_rd_q;
  logic [ETW-1:0]           ind_rd_q;
  logic [TAW-1:0]           ord_rd_q;
  logic [TW-1:0]            ear_rd_q, lat_rd_q;
  logic [DURATION_BITS-1:0] dur_mem_rd_q;
  logic                     dur_vld_rd_q;
  logic [DURATION_BITS-1:0] dur_rd;

  logic             edge_we, ind_we, ord_we, ear_we, lat_we, dur_we;
  logic [TAW-1:0]   ind_ra, ind_wa, ord_ra, ear_ra, ear_wa, lat_ra, lat_wa, dur_ra, dur_wa;
  logic [ETW-1:0]   ind_wd;
  logic [TW-1:0]    ear_wd, lat_wd;

  // Control and working registers.
  logic [CW-1:0]  tcount_q, tcount_d;
  logic [ETW-1:0] etotal_q, etotal_d;
  logic           ovf_q, ovf_d;
  logic [TCW-1:0] i_q, i_d, head_q, head_d, tail_q, tail_d;
  logic [ETW-1:0] e_q, e_d;
  logic [TAW-1:0] u_q, u_d;
  logic [TW-1:0]  acc_q, acc_d, proj_q, proj_d;

  logic           out_v_q, out_v_d, out_ld;
  logic [cps_pkg::TaskW-1:0] out_task_q, out_task_d;
  logic [TW-1:0]  out_ef_q, out_ef_d, out_lf_q, out_lf_d, out_sl_q, out_sl_d;
  logic [TW-1:0]  out_pj_q, out_pj_d;
  logic           out_crit_q, out_crit_d, out_cyc_q, out_cyc_d;
  logic           out_ovf_q, out_ovf_d, out_last_q, out_last_d;

  // Derived values.
  logic [CW-1:0]  n_w;
  logic [5:0]     ea, eb;
  logic [TAW-1:0] eb_t, i_t;
  logic [TCW-1:0] head_m1;
  logic           a_in, b_in, hit, i_last;
  logic [TCW-1:0] i_step;
  logic [XW-1:0]  fwd_sum;
  logic [TW-1:0]  fwd_t, bwd_t, dur_sat;
  logic [ETW-1:0] ind_dec;

  assign dur_rd  = dur_vld_rd_q ? dur_mem_rd_q : '0;
  assign n_w     = (tcount_q == '0) ? CW'(1)
                 : (tcount_q > CW'(MAX_TASKS)) ? CW'(MAX_TASKS) : tcount_q;
  assign ea      = edge_rd_q[11:6];
  assign eb      = edge_rd_q[5:0];
  assign eb_t    = eb[TAW-1:0];
  assign i_t     = i_q[TAW-1:0];
  assign head_m1 = head_q - TCW'(1);
  assign a_in    = {1'b0, ea} < n_w;
  assign b_in    = {1'b0, eb} < n_w;
  assign hit     = (cmd_i.phase == cps_pkg::PH_COUNT) ? (a_in && b_in)
                 : (({1'b0, ea} == CW'(u_q)) && b_in);
  assign i_last  = CW'(i_q) == (n_w - CW'(1));
  assign i_step  = i_last ? '0 : i_q + TCW'(1);
  assign ind_dec = ind_rd_q - ETW'(1);

  assign fwd_sum = XW'(acc_q) + XW'(dur_rd);
  assign fwd_t   = (fwd_sum > XW'(cps_pkg::TimeMax)) ? cps_pkg::TimeMax : fwd_sum[TW-1:0];
  assign bwd_t   = (XW'(dur_rd) > XW'(lat_rd_q)) ? '0 : TW'(XW'(lat_rd_q) - XW'(dur_rd));
  assign dur_sat = (XW'(dur_rd) > XW'(cps_pkg::TimeMax)) ? cps_pkg::TimeMax
                                                          : TW'(XW'(dur_rd));

  assign st_o.item_valid = item_i.valid;
  assign st_o.item_mode  = cps_pkg::mode_e'(item_i.mode);
  assign st_o.e_done     = e_q == etotal_q;
  assign st_o.hit        = hit;
  assign st_o.i_last     = i_last;
  assign st_o.q_empty    = head_q == tail_q;
  assign st_o.tail_short = CW'(tail_q) < n_w;
  assign st_o.head_at_n  = CW'(head_q) == n_w;
  assign st_o.head_zero  = head_q == '0;
  assign st_o.out_free   = !out_v_q || result_o.ready;

  assign item_i.ready = cmd_i.item_ready;
  assign cfg_i.ready  = 1'b1;

  // Read addresses: node stores follow the edge target while an edge is
  // checked, the popped task when it is fetched, and the task counter else.
  always_comb begin
    ind_ra = (cmd_i.op == cps_pkg::OP_ECHK) ? eb_t : i_t;
    dur_ra = (cmd_i.op == cps_pkg::OP_ECHK) ? eb_t : i_t;
    ord_ra = (cmd_i.phase == cps_pkg::PH_BWD) ? head_m1[TAW-1:0] : head_q[TAW-1:0];
    ear_ra = i_t;
    lat_ra = i_t;
    if (cmd_i.op == cps_pkg::OP_ECHK) begin
      ear_ra = eb_t;
      lat_ra = eb_t;
    end else if (cmd_i.op == cps_pkg::OP_GET) begin
      ear_ra = ord_rd_q;
      lat_ra = ord_rd_q;
    end
  end

  always_comb begin
    tcount_d = cfg_i.valid ? cfg_i.task_count : tcount_q;
    etotal_d = etotal_q;
    ovf_d    = ovf_q;
    i_d      = i_q;
    e_d      = e_q;
    head_d   = head_q;
    tail_d   = tail_q;
    u_d      = u_q;
    acc_d    = acc_q;
    proj_d   = proj_q;
    edge_we  = 1'b0;
    dur_we   = 1'b0;
    dur_wa   = item_i.task_id[TAW-1:0];
    ind_we   = 1'b0;
    ind_wa   = i_t;
    ind_wd   = '0;
    ord_we   = 1'b0;
    ear_we   = 1'b0;
    ear_wa   = i_t;
    ear_wd   = dur_sat;
    lat_we   = 1'b0;
    lat_wa   = i_t;
    lat_wd   = proj_q;
    out_ld     = 1'b0;
    out_task_d = 6'(i_q);
    out_ef_d   = ear_rd_q;
    out_lf_d   = lat_rd_q;
    out_sl_d   = (lat_rd_q > ear_rd_q) ? lat_rd_q - ear_rd_q : '0;
    out_crit_d = !(lat_rd_q > ear_rd_q);
    out_pj_d   = proj_q;
    out_cyc_d  = 1'b0;
    out_ovf_d  = ovf_q;
    out_last_d = i_last;
    unique case (cmd_i.op)
      cps_pkg::OP_LOAD: begin
        unique case (cps_pkg::mode_e'(item_i.mode))
          cps_pkg::MODE_LOAD: dur_we = CW'(item_i.task_id) < CW'(MAX_TASKS);
          cps_pkg::MODE_EDGE: begin
            if (etotal_q < ETW'(MAX_EDGES)) begin
              edge_we  = 1'b1;
              etotal_d = etotal_q + ETW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          cps_pkg::MODE_CLEAR: begin
            etotal_d = '0;
            ovf_d    = 1'b0;
          end
          default: ;
        endcase
      end
      cps_pkg::OP_START: begin
        i_d    = '0;
        e_d    = '0;
        head_d = '0;
        tail_d = '0;
      end
      cps_pkg::OP_ZERO: begin
        ind_we = 1'b1;
        i_d    = i_step;
        e_d    = '0;
      end
      cps_pkg::OP_ECHK: begin
        if (!hit) e_d = e_q + ETW'(1);
      end
      cps_pkg::OP_EUPD: begin
        e_d = e_q + ETW'(1);
        unique case (cmd_i.phase)
          cps_pkg::PH_COUNT: begin
            ind_we = 1'b1;
            ind_wa = eb_t;
            ind_wd = ind_rd_q + ETW'(1);
          end
          cps_pkg::PH_KAHN: begin
            ind_we = 1'b1;
            ind_wa = eb_t;
            ind_wd = ind_dec;
            if (ind_dec == '0 && tail_q < TCW'(MAX_TASKS)) begin
              ord_we = 1'b1;
              tail_d = tail_q + TCW'(1);
            end
          end
          cps_pkg::PH_FWD: begin
            ear_wa = eb_t;
            ear_wd = fwd_t;
            ear_we = fwd_t > ear_rd_q;
          end
          default: begin
            lat_wa = u_q;
            lat_wd = bwd_t;
            if (bwd_t < acc_q) begin
              lat_we = 1'b1;
              acc_d  = bwd_t;
            end
          end
        endcase
      end
      cps_pkg::OP_SEED_WR: begin
        if (ind_rd_q == '0) begin
          ord_we = 1'b1;
          tail_d = tail_q + TCW'(1);
        end
        i_d = i_step;
      end
      cps_pkg::OP_GET: begin
        u_d = ord_rd_q;
        if (cmd_i.phase == cps_pkg::PH_KAHN) begin
          head_d = head_q + TCW'(1);
          e_d    = '0;
        end
      end
      cps_pkg::OP_ACC: begin
        e_d = '0;
        if (cmd_i.phase == cps_pkg::PH_FWD) begin
          acc_d  = ear_rd_q;
          head_d = head_q + TCW'(1);
        end else begin
          acc_d  = lat_rd_q;
          head_d = head_m1;
        end
      end
      cps_pkg::OP_EI_WR: begin
        ear_we = 1'b1;
        i_d    = i_step;
        if (i_last) begin
          head_d = '0;
          proj_d = '0;
        end
      end
      cps_pkg::OP_PJ_WR: begin
        if (ear_rd_q > proj_q) proj_d = ear_rd_q;
        i_d = i_step;
      end
      cps_pkg::OP_LI: begin
        lat_we = 1'b1;
        i_d    = i_step;
        if (i_last) head_d = TCW'(n_w);
      end
      cps_pkg::OP_EMIT: begin
        out_ld = 1'b1;
        i_d    = i_step;
      end
      cps_pkg::OP_ERR: begin
        out_ld     = 1'b1;
        out_task_d = '0;
        out_ef_d   = '0;
        out_lf_d   = '0;
        out_sl_d   = '0;
        out_crit_d = 1'b0;
        out_pj_d   = '0;
        out_cyc_d  = 1'b1;
        out_last_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (result_o.ready) out_v_d = 1'b0;
    if (out_ld) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q  <= CW'(MAX_TASKS);
      etotal_q  <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      e_q       <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      out_v_q   <= 1'b0;
      dur_vld_q <= '0;
    end else begin
      tcount_q <= tcount_d;
      etotal_q <= etotal_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      e_q      <= e_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      out_v_q  <= out_v_d;
      if (dur_we) dur_vld_q[dur_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    acc_q  <= acc_d;
    proj_q <= proj_d;
    if (out_ld) begin
      out_task_q <= out_task_d;
      out_ef_q   <= out_ef_d;
      out_lf_q   <= out_lf_d;
      out_sl_q   <= out_sl_d;
      out_crit_q <= out_crit_d;
      out_pj_q   <= out_pj_d;
      out_cyc_q  <= out_cyc_d;
      out_ovf_q  <= out_ovf_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[etotal_q[EAW-1:0]] <= {item_i.edge_from, item_i.edge_to};
    edge_rd_q <= edge_mem[e_q[EAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ind_we) ind_mem[ind_wa] <= ind_wd;
    ind_rd_q <= ind_mem[ind_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[tail_q[TAW-1:0]] <= (cmd_i.op == cps_pkg::OP_EUPD) ? eb_t : i_t;
    ord_rd_q <= ord_mem[ord_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ear_we) ear_mem[ear_wa] <= ear_wd;
    ear_rd_q <= ear_mem[ear_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lat_we) lat_mem[lat_wa] <= lat_wd;
    lat_rd_q <= lat_mem[lat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dur_we) dur_mem[dur_wa] <= DURATION_BITS'(item_i.task_duration);
    dur_mem_rd_q <= dur_mem[dur_ra];
    dur_vld_rd_q <= dur_vld_q[dur_ra];
  end

  assign result_o.valid            = out_v_q;
  assign result_o.result_task      = out_task_q;
  assign result_o.earliest_finish  = out_ef_q;
  assign result_o.latest_finish    = out_lf_q;
  assign result_o.slack_time       = out_sl_q;
  assign result_o.on_critical_path = out_crit_q;
  assign result_o.project_time     = out_pj_q;
  assign result_o.cycle_error      = out_cyc_q;
  assign result_o.edge_overflow    = out_ovf_q;
  assign result_o.last_result      = out_last_q;

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= TCW'(MAX_TASKS))
    else $error("topological queue ran past the task store");

  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed its tail");

  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    etotal_q <= ETW'(MAX_EDGES))
    else $error("edge count beyond the edge store");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_cyc_q |-> out_last_q)
    else $error("cycle error result not marked as the last of its run");

endmodule

>>> rtl/core/critical_path_scheduler.sv
// Top level of the critical path scheduler: joins the controller and the
// datapath. Uses cps_pkg, the channel interfaces of cps_if, cps_ctrl, cps_dp.
//
// Use: item beats arrive on item_i. Mode load stores a task duration, mode
// edge appends a precedence edge, mode clear empties the edge list; each of
// these gives no result. Mode run starts an analysis: item_i.ready stays
// low until the last result beat has been loaded into the output register.
// A run gives one result beat per task in task order, task_count clipped to
// 1..MAX_TASKS tasks, or a single beat with cycle_error set when the edges
// among the counted tasks contain a cycle. The run is a sequence of
// edge-list walks through one edge-store read port: one counting walk,
// then one walk per task for each of the ordering, forward and backward
// passes, plus per-task work around the passes. cfg_i.ready is high; the
// user must write task_count on cfg_i only while the block is idle; the
// block itself does not enforce this. Reset clears durations to zero,
// empties the edge list and sets task_count to the store size; no clearing
// pass is needed. If result_o stalls, the run waits with the next result
// held in its read registers.
module critical_path_scheduler #(
  parameter int MAX_TASKS     = cps_pkg::MaxTasks,
  parameter int MAX_EDGES     = cps_pkg::MaxEdges,
  parameter int DURATION_BITS = cps_pkg::DurationBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cps_item_if.sink      item_i,
  cps_cfg_if.sink       cfg_i,
  cps_result_if.source  result_o
);

  cps_pkg::cmd_t    cmd;
  cps_pkg::status_t status;

  cps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (status),
    .cmd_o  (cmd)
  );

  cps_dp #(
    .MAX_TASKS     (MAX_TASKS),
    .MAX_EDGES     (MAX_EDGES),
    .DURATION_BITS (DURATION_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .st_o     (status),
    .item_i   (item_i),
    .cfg_i    (cfg_i),
    .result_o (result_o)
  );

endmodule

>>> dv/tb.sv
// Self-checking testbench for critical_path_scheduler: random and directed item
// beats, an in-bench schedule predictor and a result scoreboard.
// Depends on cps_pkg, the channel interfaces in cps_if and the block's top level.
`timescale 1ns / 100ps

module tb;

  typedef struct packed {
    cps_pkg::mode_e              mode;
    logic [cps_pkg::TaskW-1:0]   task_id;
    logic [15:0]                 dur;
    logic [cps_pkg::TaskW-1:0]   src;
    logic [cps_pkg::TaskW-1:0]   dst;
  } job_item_t;

  typedef struct packed {
    logic [cps_pkg::TaskW-1:0] task_no;
    logic [cps_pkg::TimeW-1:0] ef;
    logic [cps_pkg::TimeW-1:0] lf;
    logic [cps_pkg::TimeW-1:0] slack;
    logic                      crit;
    logic [cps_pkg::TimeW-1:0] proj;
    logic                      cyc_err;
    logic                      ovf;
    logic                      last;
  } sched_row_t;

  logic clk_i;
  logic rst_ni;
  logic rst_done;

  cps_item_if   item_ch ();
  cps_cfg_if    cfg_ch ();
  cps_result_if res_ch ();

  critical_path_scheduler u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .cfg_i    (cfg_ch),
    .result_o (res_ch)
  );

  // Predictor state: a copy of the block's stores.
  logic [15:0]                dur_mem [cps_pkg::MaxTasks];
  logic [11:0]                edge_mem [cps_pkg::MaxEdges];
  int unsigned                edge_cnt;
  logic                       ovf_flag;
  logic [cps_pkg::CountW-1:0] tc_reg;

  job_item_t  item_backlog [$];
  sched_row_t expected_rows [$];
  bit         failed;
  bit         item_taken;
  int         burst_left;
  int         gap_left;
  int unsigned cyc;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    rst_done = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.mode = cps_pkg::MODE_LOAD;
    item_ch.task_id = '0;
    item_ch.task_duration = '0;
    item_ch.edge_from = '0;
    item_ch.edge_to = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.task_count = '0;
    res_ch.ready = 1'b0;
    repeat (8) #10 clk_i = ~clk_i;
    rst_ni = 1'b1;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic add_item(job_item_t it);
    item_backlog = {item_backlog, it};
  endtask

  // Ordering, forward and backward passes over the edges, as the block orders them.
  task automatic schedule_analysis();
    logic [10:0]               indeg [cps_pkg::MaxTasks];
    logic [cps_pkg::TaskW-1:0] order [cps_pkg::MaxTasks];
    logic [23:0]               ef [cps_pkg::MaxTasks];
    logic [23:0]               lf [cps_pkg::MaxTasks];
    int unsigned               n, head, tail, u, a, b;
    logic [23:0]               proj, t;
    sched_row_t                row;
    n = (tc_reg == 0) ? 1 : (tc_reg > cps_pkg::MaxTasks) ? cps_pkg::MaxTasks : tc_reg;
    head = 0;
    tail = 0;
    proj = 0;
    for (int i = 0; i < cps_pkg::MaxTasks; i++) indeg[i] = 0;
    for (int e = 0; e < edge_cnt; e++) begin
      a = edge_mem[e][11:6];
      b = edge_mem[e][5:0];
      if (a < n && b < n) indeg[b]++;
    end
    for (int i = 0; i < n; i++) if (indeg[i] == 0) order[tail++] = cps_pkg::TaskW'(i);
    while (head < tail) begin
      u = order[head++];
      for (int e = 0; e < edge_cnt; e++) begin
        a = edge_mem[e][11:6];
        b = edge_mem[e][5:0];
        if (a == u && b < n) begin
          indeg[b]--;
          if (indeg[b] == 0 && tail < cps_pkg::MaxTasks) order[tail++] = cps_pkg::TaskW'(b);
        end
      end
    end
    if (tail < n) begin
      row = '0;
      row.cyc_err = 1'b1;
      row.ovf = ovf_flag;
      row.last = 1'b1;
      expected_rows = {expected_rows, row};
      return;
    end
    for (int i = 0; i < n; i++) ef[i] = 24'(dur_mem[i]);
    for (int h = 0; h < n; h++) begin
      u = order[h];
      for (int e = 0; e < edge_cnt; e++) begin
        a = edge_mem[e][11:6];
        b = edge_mem[e][5:0];
        if (a == u && b < n) begin
          t = ef[u] + 24'(dur_mem[b]);
          if (t > cps_pkg::TimeMax) t = 24'(cps_pkg::TimeMax);
          if (t > ef[b]) ef[b] = t;
        end
      end
    end
    for (int i = 0; i < n; i++) if (ef[i] > proj) proj = ef[i];
    for (int i = 0; i < n; i++) lf[i] = proj;
    for (int h = n - 1; h >= 0; h--) begin
      u = order[h];
      for (int e = 0; e < edge_cnt; e++) begin
        a = edge_mem[e][11:6];
        b = edge_mem[e][5:0];
        if (a == u && b < n) begin
          t = (lf[b] > 24'(dur_mem[b])) ? lf[b] - 24'(dur_mem[b]) : 24'd0;
          if (t < lf[u]) lf[u] = t;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      row.task_no = cps_pkg::TaskW'(i);
      row.ef = ef[i][cps_pkg::TimeW-1:0];
      row.lf = lf[i][cps_pkg::TimeW-1:0];
      row.slack = (lf[i] > ef[i]) ? cps_pkg::TimeW'(lf[i] - ef[i]) : '0;
      row.crit = (row.slack == 0);
      row.proj = proj[cps_pkg::TimeW-1:0];
      row.cyc_err = 1'b0;
      row.ovf = ovf_flag;
      row.last = (i + 1 == n);
      expected_rows = {expected_rows, row};
    end
  endtask

  // Driver: bursts of beats with random gaps, fed from the backlog.
  always @(negedge clk_i) begin
    job_item_t it;
    if (rst_done && (!item_ch.valid || item_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        item_ch.valid <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        it = item_backlog.pop_front();
        item_ch.mode <= it.mode;
        item_ch.task_id <= it.task_id;
        item_ch.task_duration <= it.dur;
        item_ch.edge_from <= it.src;
        item_ch.edge_to <= it.dst;
        item_ch.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls in turn: never, at random, ready one in five, rarely.
  always @(negedge clk_i) begin
    cyc++;
    case ((cyc / 300) % 4)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= 1'($urandom_range(0, 1));
      2: res_ch.ready <= (cyc % 5 == 0);
      default: res_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Monitor: updates the predictor on each item beat and checks result beats.
  always @(posedge clk_i) begin
    sched_row_t exp_row;
    item_taken = item_ch.valid && item_ch.ready;
    if (item_taken) begin
      case (cps_pkg::mode_e'(item_ch.mode))
        cps_pkg::MODE_LOAD: dur_mem[item_ch.task_id] = item_ch.task_duration;
        cps_pkg::MODE_EDGE: begin
          if (edge_cnt < cps_pkg::MaxEdges) begin
            edge_mem[edge_cnt] = {item_ch.edge_from, item_ch.edge_to};
            edge_cnt++;
          end else begin
            ovf_flag = 1'b1;
          end
        end
        cps_pkg::MODE_CLEAR: begin
          edge_cnt = 0;
          ovf_flag = 1'b0;
        end
        default: schedule_analysis();
      endcase
    end
    if (res_ch.valid && res_ch.ready) begin
      if (expected_rows.size() == 0) begin
        $error("result beat for task %0d with nothing expected", res_ch.result_task);
        failed = 1'b1;
      end else begin
        exp_row = expected_rows.pop_front();
        if (res_ch.result_task !== exp_row.task_no) begin
          $error("result_task: expected %0d, got %0d", exp_row.task_no, res_ch.result_task);
          failed = 1'b1;
        end
        if (res_ch.earliest_finish !== exp_row.ef) begin
          $error("earliest_finish: expected %0d, got %0d", exp_row.ef,
                 res_ch.earliest_finish);
          failed = 1'b1;
        end
        if (res_ch.latest_finish !== exp_row.lf) begin
          $error("latest_finish: expected %0d, got %0d", exp_row.lf, res_ch.latest_finish);
          failed = 1'b1;
        end
        if (res_ch.slack_time !== exp_row.slack) begin
          $error("slack_time: expected %0d, got %0d", exp_row.slack, res_ch.slack_time);
          failed = 1'b1;
        end
        if (res_ch.on_critical_path !== exp_row.crit) begin
          $error("on_critical_path: expected %0d, got %0d", exp_row.crit,
                 res_ch.on_critical_path);
          failed = 1'b1;
        end
        if (res_ch.project_time !== exp_row.proj) begin
          $error("project_time: expected %0d, got %0d", exp_row.proj, res_ch.project_time);
          failed = 1'b1;
        end
        if (res_ch.cycle_error !== exp_row.cyc_err) begin
          $error("cycle_error: expected %0d, got %0d", exp_row.cyc_err, res_ch.cycle_error);
          failed = 1'b1;
        end
        if (res_ch.edge_overflow !== exp_row.ovf) begin
          $error("edge_overflow: expected %0d, got %0d", exp_row.ovf, res_ch.edge_overflow);
          failed = 1'b1;
        end
        if (res_ch.last_result !== exp_row.last) begin
          $error("last_result: expected %0d, got %0d", exp_row.last, res_ch.last_result);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic job_item_t mk(cps_pkg::mode_e m, int id, int d, int s, int t);
    job_item_t it;
    it.mode = m;
    it.task_id = cps_pkg::TaskW'(id);
    it.dur = 16'(d);
    it.src = cps_pkg::TaskW'(s);
    it.dst = cps_pkg::TaskW'(t);
    return it;
  endfunction

  // Holds the stimulus until every queued beat is taken and every result has
  // come, then lets a load or edge beat still in flight settle.
  task automatic wait_idle();
    while (item_backlog.size() > 0 || item_ch.valid || expected_rows.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_task_count(int v);
    wait_idle();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.task_count <= cps_pkg::CountW'(v);
    do @(posedge clk_i); while (!cfg_ch.ready);
    tc_reg = cps_pkg::CountW'(v);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int rand_dur();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 65535);
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  initial begin
    int n, s, t, ne;
    int perm [cps_pkg::MaxTasks];
    for (int i = 0; i < cps_pkg::MaxTasks; i++) dur_mem[i] = '0;
    edge_cnt = 0;
    ovf_flag = 1'b0;
    tc_reg = cps_pkg::CountW'(cps_pkg::MaxTasks);
    failed = 1'b0;
    burst_left = 0;
    gap_left = 0;
    cyc = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    rst_done = 1'b1;

    // Directed: extremes of duration, chain, duplicate edge, self edge, clear.
    add_item(mk(cps_pkg::MODE_RUN, 0, 0, 0, 0));
    add_item(mk(cps_pkg::MODE_LOAD, 0, 16'hFFFF, 0, 0));
    add_item(mk(cps_pkg::MODE_LOAD, 63, 16'hFFFF, 0, 0));
    add_item(mk(cps_pkg::MODE_LOAD, 5, 1, 0, 0));
    add_item(mk(cps_pkg::MODE_EDGE, 0, 0, 0, 5));
    add_item(mk(cps_pkg::MODE_EDGE, 0, 0, 5, 63));
    add_item(mk(cps_pkg::MODE_EDGE, 0, 0, 5, 63));
    add_item(mk(cps_pkg::MODE_EDGE, 0, 0, 0, 63));
    add_item(mk(cps_pkg::MODE_RUN, 0, 0, 0, 0));
    add_item(mk(cps_pkg::MODE_EDGE, 0, 0, 63, 63));
    add_item(mk(cps_pkg::MODE_RUN, 0, 0, 0, 0));
    add_item(mk(cps_pkg::MODE_CLEAR, 0, 0, 0, 0));
    add_item(mk(cps_pkg::MODE_EDGE, 0, 0, 1, 2));
    add_item(mk(cps_pkg::MODE_EDGE, 0, 0, 2, 1));
    add_item(mk(cps_pkg::MODE_RUN, 0, 0, 0, 0));
    // A two-task cycle among tasks outside the count is ignored.
    write_task_count(0);
    add_item(mk(cps_pkg::MODE_RUN, 0, 0, 0, 0));
    write_task_count(2);
    add_item(mk(cps_pkg::MODE_EDGE, 0, 0, 0, 1));
    add_item(mk(cps_pkg::MODE_RUN, 0, 0, 0, 0));
    write_task_count(127);
    add_item(mk(cps_pkg::MODE_CLEAR, 0, 0, 0, 0));
    add_item(mk(cps_pkg::MODE_RUN, 0, 0, 0, 0));

    // Random phases: a task count, then well-formed DAGs with some noise.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: n = 64;
        1: n = 1;
        2: n = 127;
        default: n = $urandom_range(2, 12);
      endcase
      write_task_count(n);
      if (n > cps_pkg::MaxTasks) n = cps_pkg::MaxTasks;
      for (int i = 0; i < n; i++) perm[i] = i;
      perm.shuffle();
      add_item(mk(cps_pkg::MODE_CLEAR, 0, 0, 0, 0));
      for (int r = 0; r < 2; r++) begin
        repeat ($urandom_range(2, 6))
          add_item(mk(cps_pkg::MODE_LOAD, $urandom_range(0, 63), rand_dur(), 0, 0));
        ne = $urandom_range(1, 6);
        for (int e = 0; e < ne; e++) begin
          if ($urandom_range(0, 9) == 0) begin
            add_item(mk(cps_pkg::MODE_EDGE, 0, 0, $urandom_range(0, 63),
                        $urandom_range(0, 63)));
          end else if (n > 1) begin
            s = $urandom_range(0, n - 2);
            t = $urandom_range(s + 1, n - 1);
            add_item(mk(cps_pkg::MODE_EDGE, 0, 0, perm[s], perm[t]));
          end
        end
        add_item(mk(cps_pkg::MODE_RUN, 0, 0, 0, 0));
      end
    end

    wait_idle();
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
